// ===== design/wbps_pkg.sv =====
package wbps_pkg;

  // Pattern byte that matches any data byte
  localparam logic [7:0] WILDCARD_BYTE = 8'hCC;

  // The two pattern registers hold this many bytes in all
  localparam int PATTERN_REG_BYTES = 16;

  // Configuration port widths
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 5;
  localparam int LEN_W      = 5;

  // Stream payload widths
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 32;

  // Register index, taken from paddr[4:3] (registers sit 8 bytes apart)
  typedef enum logic [1:0] {
    REG_PATTERN_LOW  = 2'd0,
    REG_PATTERN_HIGH = 2'd1,
    REG_PATTERN_LEN  = 2'd2
  } reg_index_t;

endpackage

// ===== design/wildcard_byte_pattern_scanner.sv =====
// Byte pattern scanner: takes one byte word per clock on the s_ side and looks for
// the first place in a region where the programmed pattern (up to 16 bytes,
// 0xCC in the pattern matches any byte) lines up with the latest bytes. The
// window of recent bytes is compared against the pattern for every possible
// length at once, so a byte is taken every cycle and its result, if any,
// appears on the m_ side in the cycle after the byte is accepted; s_tready only
// drops while a result waits on a low m_tready. Per region at most one word
// comes out: found=1 with the offset of the match start, or found=0 on the
// region's last byte. s_tuser=1 opens a new region. Program the pattern
// registers (byte 0x00 low bytes, 0x08 high bytes, 0x10 length) only while
// the scanner is idle.
module wildcard_byte_pattern_scanner #(
  parameter int MAX_PATTERN_BYTES = 16,
  parameter int OFFSET_BITS       = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  // input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [wbps_pkg::IN_DATA_W-1:0]    s_tdata,   // [7:0] data_byte
  input  logic                              s_tuser,   // [0] first_byte
  input  logic                              s_tlast,   // last_byte
  // result stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [wbps_pkg::OUT_DATA_W-1:0]   m_tdata,   // [31:0] match_offset
  output logic                              m_tuser,   // [0] found
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [wbps_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [wbps_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [wbps_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import wbps_pkg::*;

  localparam int LIMIT = (MAX_PATTERN_BYTES < PATTERN_REG_BYTES) ?
                         MAX_PATTERN_BYTES : PATTERN_REG_BYTES;
  localparam int SEL_W = $clog2(LIMIT + 1);

  // configuration registers
  logic [CFG_DATA_W-1:0] pattern_low;
  logic [CFG_DATA_W-1:0] pattern_high;
  logic [LEN_W-1:0]      pattern_len;

  // scan state
  logic [7:0]             window [MAX_PATTERN_BYTES];
  logic [OFFSET_BITS-1:0] count;
  logic                   done;

  // datapath
  logic                   accept;
  logic                   cfg_write;
  reg_index_t             cfg_index;
  logic [7:0]             pat [PATTERN_REG_BYTES];
  logic [7:0]             window_next [MAX_PATTERN_BYTES];
  logic [OFFSET_BITS-1:0] count_base;
  logic [OFFSET_BITS-1:0] count_next;
  logic                   done_base;
  logic [LEN_W-1:0]       len_used;
  logic [LIMIT:0]         len_hit;
  logic                   match;
  logic                   emit;
  logic [OFFSET_BITS-1:0] offset;

  // APB register file
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_index = reg_index_t'(paddr[4:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low  <= '0;
      pattern_high <= '0;
      pattern_len  <= LEN_W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PATTERN_LOW:  pattern_low  <= pwdata;
        REG_PATTERN_HIGH: pattern_high <= pwdata;
        REG_PATTERN_LEN:  pattern_len  <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_index)
      REG_PATTERN_LOW:  prdata = pattern_low;
      REG_PATTERN_HIGH: prdata = pattern_high;
      REG_PATTERN_LEN:  prdata = CFG_DATA_W'(pattern_len);
      default:          prdata = '0;
    endcase
  end

  // pattern bytes, byte 0 lowest
  always_comb begin
    for (int i = 0; i < PATTERN_REG_BYTES / 2; i++) begin
      pat[i]                         = pattern_low[8*i +: 8];
      pat[i + PATTERN_REG_BYTES / 2] = pattern_high[8*i +: 8];
    end
  end

  // length in use, saturated
  assign len_used = (pattern_len > LEN_W'(LIMIT)) ? LEN_W'(LIMIT) : pattern_len;

  // a new region starts from an empty count; old window bytes are never
  // looked at since the count gates every compare
  assign count_base = s_tuser ? '0 : count;
  assign done_base  = s_tuser ? 1'b0 : done;
  assign count_next = (count_base == '1) ? count_base : count_base + 1'b1;

  always_comb begin
    window_next[0] = s_tdata;
    for (int k = 1; k < MAX_PATTERN_BYTES; k++) begin
      window_next[k] = window[k-1];
    end
  end

  // compare the window against every pattern length at once; for length l,
  // pattern byte i lines up with window entry l-1-i
  always_comb begin
    logic hit;
    len_hit[0] = 1'b1;
    for (int l = 1; l <= LIMIT; l++) begin
      hit = 1'b1;
      for (int i = 0; i < l; i++) begin
        if (pat[i] != WILDCARD_BYTE && window_next[l-1-i] != pat[i]) begin
          hit = 1'b0;
        end
      end
      len_hit[l] = hit;
    end
  end

  assign match = (len_used == '0) ||
                 ((count_next >= OFFSET_BITS'(len_used)) && len_hit[len_used[SEL_W-1:0]]);
  assign offset = (len_used == '0) ? count_base : count_next - OFFSET_BITS'(len_used);
  assign emit   = !done_base && (match || s_tlast);

  // handshake: take a byte whenever the result slot is free or draining
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // window shift
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
        window[k] <= window_next[k];
      end
    end
  end

  // count and done mark
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else if (accept) begin
      count <= count_next;
      done  <= done_base || emit;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept && emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      m_tuser <= match;
      m_tdata <= match ? OUT_DATA_W'(offset) : '0;
    end
  end

endmodule

// ===== design/wbps_checker.sv =====
module wbps_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tvalid,
  input logic                              s_tready,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [wbps_pkg::OUT_DATA_W-1:0]   m_tdata,   // [31:0] match_offset
  input logic                              m_tuser    // [0] found
);
  import wbps_pkg::*;

  // result slot empty after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result word valid right after reset");

  // a stalled result word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    $past(m_tvalid && !m_tready) && !$past(rst) |-> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result word changed");

  // the input side never waits on an empty result slot
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty result slot");

  // a result word only follows an accepted byte or a held word
  a_cause: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !$past(rst) |-> $past(s_tvalid && s_tready) || $past(m_tvalid && !m_tready))
    else $error("result word without an accepted byte");

  // a not-found word carries a zero offset
  a_notfound_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("not-found result with nonzero offset");

endmodule

bind wildcard_byte_pattern_scanner wbps_checker u_wbps_checker (.*);
